### sv/rbd_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// rbd_pkg: shared types and codes for the run-length bitmap decoder
// Commands, the front-to-back queue entry and the result beat.
// ---------------------------------------------------------------------------
package rbd_pkg;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_BYTE  = 2'd1,
        CMD_STEP  = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    // One input beat as the front part hands it to the back part.
    typedef struct packed {
        t_cmd        cmd;
        logic [7:0]  data_byte;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic        draw_color;
        logic        mirror_image;
    } t_item;

    // One result beat.
    typedef struct packed {
        logic       upper_valid;
        logic [9:0] upper_index;
        logic [7:0] upper_value;
        logic       lower_valid;
        logic [9:0] lower_index;
        logic [7:0] lower_value;
        logic       set_mode;
        logic       need_byte;
        logic       finished;
    } t_result;

endpackage
`default_nettype wire

### sv/rbd_if.sv
`default_nettype none
// ---------------------------------------------------------------------------
// rbd_in_if / rbd_out_if: valid-ready channels of the bitmap decoder
// Each carries valid, ready and one payload beat.
// ---------------------------------------------------------------------------
interface rbd_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [7:0]  data_byte;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic        draw_color;
    logic        mirror_image;

    modport source (output valid, command, data_byte, pos_x, pos_y, draw_color,
                    mirror_image, input ready);
    modport sink (input valid, command, data_byte, pos_x, pos_y, draw_color,
                  mirror_image, output ready);
endinterface

interface rbd_out_if;
    logic       valid;
    logic       ready;
    logic       upper_valid;
    logic [9:0] upper_index;
    logic [7:0] upper_value;
    logic       lower_valid;
    logic [9:0] lower_index;
    logic [7:0] lower_value;
    logic       set_mode;
    logic       need_byte;
    logic       finished;

    modport source (output valid, upper_valid, upper_index, upper_value, lower_valid,
                    lower_index, lower_value, set_mode, need_byte, finished,
                    input ready);
    modport sink (input valid, upper_valid, upper_index, upper_value, lower_valid,
                  lower_index, lower_value, set_mode, need_byte, finished,
                  output ready);
endinterface
`default_nettype wire

### sv/rle_bitmap_decode_blit.sv
`default_nettype none
// ---------------------------------------------------------------------------
// rle_bitmap_decode_blit: run-length 1-bit bitmap decoder for a paged display
// Front accepts beats into a queue; the back engine decodes and emits writes.
// ---------------------------------------------------------------------------
// Every input beat (start, byte or step) yields exactly one result beat. The
// block takes one beat per cycle while the output does not stall: a two-entry
// queue in front of the decode engine plus a result register behind it let
// input and output stall independently. An accepted beat is held in the queue
// and then in the result register.
module rle_bitmap_decode_blit #(
    parameter int SCREEN_WIDTH  = 128,
    parameter int SCREEN_HEIGHT = 64
) (
    input wire         i_clk,
    input wire         i_rst_n,
    rbd_in_if.sink     i_in,
    rbd_out_if.source  o_out
);
    import rbd_pkg::*;

    t_item   in_item, q_item;
    t_result res;
    logic    q_full, q_valid, q_pop, push;

    // Front: classify the raw command and accept while the queue has room.
    always_comb begin
        in_item.cmd          = t_cmd'(i_in.command);
        in_item.data_byte    = i_in.data_byte;
        in_item.pos_x        = i_in.pos_x;
        in_item.pos_y        = i_in.pos_y;
        in_item.draw_color   = i_in.draw_color;
        in_item.mirror_image = i_in.mirror_image;
    end
    assign i_in.ready = !q_full;
    assign push       = i_in.valid && !q_full;

    rbd_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_item(in_item),
        .o_full(q_full), .o_valid(q_valid), .i_pop(q_pop), .o_item(q_item)
    );

    rbd_back #(.SCREEN_WIDTH(SCREEN_WIDTH), .SCREEN_HEIGHT(SCREEN_HEIGHT)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(q_valid), .i_item(q_item),
        .o_pop(q_pop), .o_valid(o_out.valid), .o_res(res), .i_ready(o_out.ready)
    );

    assign o_out.upper_valid = res.upper_valid;
    assign o_out.upper_index = res.upper_index;
    assign o_out.upper_value = res.upper_value;
    assign o_out.lower_valid = res.lower_valid;
    assign o_out.lower_index = res.lower_index;
    assign o_out.lower_value = res.lower_value;
    assign o_out.set_mode    = res.set_mode;
    assign o_out.need_byte   = res.need_byte;
    assign o_out.finished    = res.finished;

    // A pop never happens from an empty queue.
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid) else $error("pop from empty queue");

    // A stalled result beat holds its payload.
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |=> $stable(res)) else $error("result changed");

    // A step result never reports both a stall and a write.
    a_need_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && res.need_byte |-> !res.upper_valid && !res.lower_valid)
        else $error("write on stalled step");
endmodule
`default_nettype wire

### sv/rbd_queue.sv
`default_nettype none
// ---------------------------------------------------------------------------
// rbd_queue: two-entry queue between the front and the back part
// Full-rate flow: a beat may enter while another leaves in the same cycle.
// ---------------------------------------------------------------------------
module rbd_queue (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_push,
    input  rbd_pkg::t_item i_item,
    output logic           o_full,
    output logic           o_valid,
    input  wire            i_pop,
    output rbd_pkg::t_item o_item
);
    import rbd_pkg::*;

    t_item      r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_mem[r_rp];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_item;
    end
endmodule
`default_nettype wire

### sv/rbd_back.sv
`default_nettype none
// ---------------------------------------------------------------------------
// rbd_back: decode engine of the bitmap decoder
// Executes one queued beat per cycle while its result register is free or drains, and registers its result beat.
// ---------------------------------------------------------------------------
module rbd_back #(
    parameter int SCREEN_WIDTH  = 128,
    parameter int SCREEN_HEIGHT = 64
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    input  rbd_pkg::t_item   i_item,
    output logic             o_pop,
    output logic             o_valid,
    output rbd_pkg::t_result o_res,
    input  wire              i_ready
);
    import rbd_pkg::*;

    localparam int Pages = SCREEN_HEIGHT / 8;

    typedef enum logic [2:0] {
        PH_IDLE, PH_HDR_W, PH_HDR_H, PH_HDR_C, PH_PREFIX, PH_LEN, PH_SPAN, PH_DONE
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_mask, n_mask, r_sbyte, n_sbyte;
    logic [4:0]  r_fcnt, n_fcnt, r_clen, n_clen;
    logic [15:0] r_fval, n_fval;
    logic [8:0]  r_w, n_w, r_h, n_h, r_col, n_col;
    logic        r_scol, n_scol;
    logic [16:0] r_left, n_left;
    logic [7:0]  r_pk, n_pk, r_pbit, n_pbit;
    logic [5:0]  r_row, n_row;
    logic signed [13:0] r_page, n_page;
    logic [2:0]  r_shift, n_shift;
    logic signed [15:0] r_ox, n_ox;
    logic [1:0]  r_flags, n_flags;
    logic        r_ovalid;
    t_result     r_res, n_res;

    logic        go, b;
    logic [7:0]  pk_new;
    logic [6:0]  rows;
    logic signed [17:0] brow, col, sy;
    logic [3:0]  inv_sh;

    // The engine advances whenever a beat is queued and the result register is free or drains.
    assign go    = i_valid && (!r_ovalid || i_ready);
    assign o_pop = go;
    assign o_valid = r_ovalid;
    assign o_res   = r_res;

    assign b      = |(r_sbyte & r_mask);
    assign pk_new = r_scol ? (r_pk | r_pbit) : r_pk;
    assign rows   = 7'((10'(r_h) + 10'd7) >> 3);
    assign brow   = 18'(r_page) + 18'(r_row);
    assign col    = 18'(r_ox) + 18'(r_col);
    assign sy     = 18'(r_page) * 18'sd8 + 18'(r_shift);
    assign inv_sh = 4'd8 - 4'(r_shift);

    // Next-state logic for one beat.
    always_comb begin
        n_phase = r_phase; n_mask = r_mask; n_sbyte = r_sbyte; n_fcnt = r_fcnt;
        n_clen = r_clen; n_fval = r_fval; n_w = r_w; n_h = r_h; n_col = r_col;
        n_scol = r_scol; n_left = r_left; n_pk = r_pk; n_pbit = r_pbit;
        n_row = r_row; n_page = r_page; n_shift = r_shift; n_ox = r_ox;
        n_flags = r_flags;
        n_res = '0;
        case (i_item.cmd)
            CMD_START: begin
                n_ox    = signed'(i_item.pos_x);
                n_shift = i_item.pos_y[2:0];
                // Truncating division of (y - y mod 8) is exact: arithmetic shift.
                n_page  = 14'(signed'(i_item.pos_y) >>> 3);
                n_flags = {i_item.mirror_image, i_item.draw_color};
                n_mask = '0; n_sbyte = '0; n_fcnt = '0; n_fval = '0; n_clen = 5'd1;
                n_pk = '0; n_pbit = 8'd1; n_col = '0; n_row = '0;
                n_left = '0; n_scol = 1'b0;
                n_phase = PH_HDR_W;
            end
            CMD_BYTE: begin
                n_sbyte = i_item.data_byte;
                n_mask  = 8'd1;
            end
            CMD_STEP: begin
                case (r_phase)
                    PH_DONE: n_res.finished = 1'b1;
                    PH_HDR_W, PH_HDR_H, PH_HDR_C, PH_PREFIX, PH_LEN: begin
                        if (r_mask == 8'd0) begin
                            n_res.need_byte = 1'b1;
                        end else begin
                            n_mask = r_mask << 1;
                            case (r_phase)
                                PH_HDR_W, PH_HDR_H: begin
                                    n_fval = r_fval | (16'(b) << r_fcnt[3:0]);
                                    n_fcnt = r_fcnt + 5'd1;
                                    if (r_fcnt == 5'd7) begin
                                        if (r_phase == PH_HDR_W) n_w = 9'(n_fval[7:0]) + 9'd1;
                                        else n_h = 9'(n_fval[7:0]) + 9'd1;
                                        n_fval = '0; n_fcnt = '0;
                                        n_phase = (r_phase == PH_HDR_W) ? PH_HDR_H : PH_HDR_C;
                                    end
                                end
                                PH_HDR_C: begin
                                    n_scol = b;
                                    if (18'(r_ox) + signed'(18'(r_w)) < 18'sd0
                                        || r_ox > 16'(SCREEN_WIDTH - 1)
                                        || sy + signed'(18'(r_h)) < 18'sd0
                                        || sy > 18'(SCREEN_HEIGHT - 1)) begin
                                        n_phase = PH_DONE;
                                        n_res.finished = 1'b1;
                                    end else begin
                                        n_col = r_flags[1] ? r_w - 9'd1 : 9'd0;
                                        n_row = '0; n_pk = '0; n_pbit = 8'd1;
                                        n_clen = 5'd1;
                                        n_phase = PH_PREFIX;
                                    end
                                end
                                PH_PREFIX: begin
                                    if (!b) begin
                                        n_clen = (r_clen >= 5'd29) ? 5'd31 : r_clen + 5'd2;
                                    end else begin
                                        n_fval = '0; n_fcnt = '0;
                                        n_phase = PH_LEN;
                                    end
                                end
                                default: begin
                                    if (!r_fcnt[4]) n_fval = r_fval | (16'(b) << r_fcnt[3:0]);
                                    n_fcnt = r_fcnt + 5'd1;
                                    if (n_fcnt >= r_clen) begin
                                        n_left = 17'(n_fval) + 17'd1;
                                        n_phase = PH_SPAN;
                                    end
                                end
                            endcase
                        end
                    end
                    PH_SPAN: begin
                        n_pk   = pk_new;
                        n_pbit = r_pbit << 1;
                        if (r_pbit[7]) begin
                            // Clipped writes to this page and the page below.
                            if (brow <= 18'(Pages - 1) && brow > -18'sd2 && col >= 0
                                && col <= 18'(SCREEN_WIDTH - 1)) begin
                                if (brow >= 0) begin
                                    n_res.upper_valid = 1'b1;
                                    n_res.upper_index = 10'(brow * 18'(SCREEN_WIDTH) + col);
                                    n_res.upper_value = pk_new << r_shift;
                                end
                                if (r_shift != 3'd0 && brow < 18'(Pages - 1)) begin
                                    n_res.lower_valid = 1'b1;
                                    n_res.lower_index =
                                        10'((brow + 18'sd1) * 18'(SCREEN_WIDTH) + col);
                                    n_res.lower_value = pk_new >> inv_sh;
                                end
                            end
                            if (!r_flags[1]) begin
                                if (r_col + 9'd1 >= r_w) begin
                                    n_col = '0; n_row = r_row + 6'd1;
                                end else n_col = r_col + 9'd1;
                            end else if (r_col == 9'd0) begin
                                n_col = r_w - 9'd1; n_row = r_row + 6'd1;
                            end else n_col = r_col - 9'd1;
                            n_pk = '0; n_pbit = 8'd1;
                        end
                        n_left = r_left - 17'd1;
                        if (7'(n_row) >= rows) begin
                            n_phase = PH_DONE;
                            n_res.finished = 1'b1;
                        end else if (n_left == 17'd0) begin
                            n_scol = ~r_scol;
                            n_clen = 5'd1;
                            n_phase = PH_PREFIX;
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
        n_res.set_mode = n_flags[0];
    end

    // Decoder state and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE; r_mask <= '0; r_sbyte <= '0; r_fcnt <= '0;
            r_clen <= 5'd1; r_fval <= '0; r_w <= '0; r_h <= '0; r_col <= '0;
            r_scol <= 1'b0; r_left <= '0; r_pk <= '0; r_pbit <= 8'd1; r_row <= '0;
            r_page <= '0; r_shift <= '0; r_ox <= '0; r_flags <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (go) begin
                r_phase <= n_phase; r_mask <= n_mask; r_sbyte <= n_sbyte;
                r_fcnt <= n_fcnt; r_clen <= n_clen; r_fval <= n_fval; r_w <= n_w;
                r_h <= n_h; r_col <= n_col; r_scol <= n_scol; r_left <= n_left;
                r_pk <= n_pk; r_pbit <= n_pbit; r_row <= n_row; r_page <= n_page;
                r_shift <= n_shift; r_ox <= n_ox; r_flags <= n_flags;
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) r_res <= n_res;
    end
endmodule
`default_nettype wire
